### src/vbrf_pkg.sv
`timescale 1ns / 1ps

package vbrf_pkg;

    localparam int unsigned ROTATE_CCW = 0;

    localparam int unsigned COL_W   = 10;
    localparam int unsigned ROW_W   = 9;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned IDX_W   = 19;
    localparam int unsigned CFG_W   = 10;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [ROW_W-1:0] TINT_PART  = 9'd7;
    localparam logic [ROW_W-1:0] KEEP_PART  = 9'd9;
    localparam logic [ROW_W-1:0] TINT_RED   = 9'd5;
    localparam logic [ROW_W-1:0] TINT_GREEN = 9'd10;
    localparam logic [ROW_W-1:0] TINT_BLUE  = 9'd5;

    localparam logic [COL_W-1:0] WIDTH_RESET  = 10'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 9'd480;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VEIL_LEFT     = 3'd0,
        REG_VEIL_TOP      = 3'd1,
        REG_VEIL_RIGHT    = 3'd2,
        REG_VEIL_BOTTOM   = 3'd3,
        REG_REGION_LEFT   = 3'd4,
        REG_REGION_TOP    = 3'd5,
        REG_REGION_WIDTH  = 3'd6,
        REG_REGION_HEIGHT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [COL_W-1:0] veil_left;
        logic [ROW_W-1:0] veil_top;
        logic [COL_W-1:0] veil_right;
        logic [ROW_W-1:0] veil_bottom;
        logic [COL_W-1:0] region_left;
        logic [ROW_W-1:0] region_top;
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_pix_item;

endpackage

### src/vbrf_cfg.sv
`timescale 1ns / 1ps

module vbrf_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vbrf_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [vbrf_pkg::CFG_W-1:0]     i_cfg_data,
    output vbrf_pkg::t_cfg                 o_cfg
);
    import vbrf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.veil_left   <= '0;
            r_cfg.veil_top    <= '0;
            r_cfg.veil_right  <= '0;
            r_cfg.veil_bottom <= '0;
            r_cfg.region_left <= '0;
            r_cfg.region_top  <= '0;
            r_cfg.width       <= WIDTH_RESET;
            r_cfg.height      <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_VEIL_LEFT:     r_cfg.veil_left   <= i_cfg_data;
                REG_VEIL_TOP:      r_cfg.veil_top    <= i_cfg_data[ROW_W-1:0];
                REG_VEIL_RIGHT:    r_cfg.veil_right  <= i_cfg_data;
                REG_VEIL_BOTTOM:   r_cfg.veil_bottom <= i_cfg_data[ROW_W-1:0];
                REG_REGION_LEFT:   r_cfg.region_left <= i_cfg_data;
                REG_REGION_TOP:    r_cfg.region_top  <= i_cfg_data[ROW_W-1:0];
                REG_REGION_WIDTH:  r_cfg.width       <= i_cfg_data;
                REG_REGION_HEIGHT: r_cfg.height      <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // zero size behaves as one
    always_comb begin
        o_cfg = r_cfg;
        if (r_cfg.width == '0) begin
            o_cfg.width = COL_W'(1);
        end
        if (r_cfg.height == '0) begin
            o_cfg.height = ROW_W'(1);
        end
    end

endmodule

### src/vbrf_pos.sv
`timescale 1ns / 1ps

module vbrf_pos (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vbrf_pkg::t_cfg             i_cfg,
    input  logic                       i_in_valid,
    input  logic [vbrf_pkg::PIX_W-1:0] i_pixel_in,
    output logic                       o_in_stall,
    input  logic                       i_adv,
    output logic                       o_item_valid,
    output vbrf_pkg::t_pix_item        o_item
);
    import vbrf_pkg::*;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] col_c;
    logic [ROW_W-1:0] row_c;
    logic             r_valid;
    t_pix_item        r_item;
    logic             take;

    assign o_in_stall   = r_valid && !i_adv;
    assign take         = i_in_valid && !o_in_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        col_c = (r_col < i_cfg.width)  ? r_col : i_cfg.width - COL_W'(1);
        row_c = (r_row < i_cfg.height) ? r_row : i_cfg.height - ROW_W'(1);
        if ({1'b0, col_c} + 11'd1 >= {1'b0, i_cfg.width}) begin
            n_col = '0;
            n_row = ({1'b0, row_c} + 10'd1 >= {1'b0, i_cfg.height}) ? '0
                                                                   : row_c + ROW_W'(1);
        end else begin
            n_col = col_c + COL_W'(1);
            n_row = row_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (take) begin
                r_valid <= 1'b1;
            end else if (i_adv) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.pixel <= i_pixel_in;
            r_item.col   <= col_c;
            r_item.row   <= row_c;
        end
    end

endmodule

### src/vbrf_blend.sv
`timescale 1ns / 1ps

module vbrf_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vbrf_pkg::t_cfg             i_cfg,
    input  logic                       i_item_valid,
    input  vbrf_pkg::t_pix_item        i_item,
    output logic                       o_adv,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [vbrf_pkg::PIX_W-1:0] o_pixel_out,
    output logic [vbrf_pkg::IDX_W-1:0] o_buffer_index,
    output logic                       o_was_veiled,
    output logic                       o_last
);
    import vbrf_pkg::*;

    logic                r_out_valid;
    logic [PIX_W-1:0]    r_pixel;
    logic [IDX_W-1:0]    r_index;
    logic                r_veiled;
    logic                r_last;
    logic                load;

    logic [COL_W:0]      ax;
    logic [ROW_W:0]      ay;
    logic                veiled;
    logic [COL_W-1:0]    mul_a;
    logic [ROW_W-1:0]    add_b;
    logic [IDX_W:0]      prod;
    logic [IDX_W-1:0]    index;
    logic [ROW_W-1:0]    red_s;
    logic [ROW_W:0]      grn_s;
    logic [ROW_W-1:0]    blu_s;
    logic [PIX_W-1:0]    dimmed;
    logic                last;

    assign load  = !r_out_valid || !i_out_stall;
    assign o_adv = load;

    always_comb begin
        ax = {1'b0, i_cfg.region_left} + {1'b0, i_item.col};
        ay = {1'b0, i_cfg.region_top} + {1'b0, i_item.row};
        veiled = (i_cfg.veil_right > i_cfg.veil_left)
              && (ax >= {1'b0, i_cfg.veil_left}) && (ax < {1'b0, i_cfg.veil_right})
              && (ay >= {1'b0, i_cfg.veil_top}) && (ay < {1'b0, i_cfg.veil_bottom});

        if (ROTATE_CCW != 0) begin
            mul_a = i_cfg.width - COL_W'(1) - i_item.col;
            add_b = i_item.row;
        end else begin
            mul_a = i_item.col;
            add_b = i_cfg.height - ROW_W'(1) - i_item.row;
        end
        prod  = (IDX_W+1)'(mul_a) * (IDX_W+1)'(i_cfg.height);
        index = prod[IDX_W-1:0] + IDX_W'(add_b);

        last = (i_item.col == i_cfg.width - COL_W'(1))
            && (i_item.row == i_cfg.height - ROW_W'(1));

        red_s = ROW_W'(i_item.pixel[15:11]) * KEEP_PART + TINT_RED * TINT_PART;
        grn_s = (ROW_W+1)'(i_item.pixel[10:5]) * (ROW_W+1)'(KEEP_PART)
              + (ROW_W+1)'(TINT_GREEN * TINT_PART);
        blu_s = ROW_W'(i_item.pixel[4:0]) * KEEP_PART + TINT_BLUE * TINT_PART;
        dimmed = {red_s[8:4], grn_s[9:4], blu_s[8:4]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_item_valid) begin
            r_pixel  <= veiled ? dimmed : i_item.pixel;
            r_index  <= index;
            r_veiled <= veiled;
            r_last   <= last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_pixel;
    assign o_buffer_index = r_index;
    assign o_was_veiled   = r_veiled;
    assign o_last         = r_last;

endmodule

### src/veil_blend_rotate_flush.sv
`timescale 1ns / 1ps
// An accepted pixel sits in the input register and then shows on the outputs
// from the result register (holding the blend and index product).
// Throughput: one pixel per cycle; each stage loads whenever the stage after it moves,
// and an output stall holds both stages and the input.
// Reset (synchronous, active low) clears both pipeline valids and the column and
// row counters, and loads the registers with their defaults (640 x 480 region).
module veil_blend_rotate_flush (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vbrf_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [vbrf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [vbrf_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [vbrf_pkg::PIX_W-1:0]     o_pixel_out,
    output logic [vbrf_pkg::IDX_W-1:0]     o_buffer_index,
    output logic                           o_was_veiled,
    output logic                           o_last
);
    import vbrf_pkg::*;

    t_cfg      cfg;
    t_pix_item item;
    logic      item_valid;
    logic      adv;

    vbrf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vbrf_pos u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .i_pixel_in   (i_pixel_in),
        .o_in_stall   (o_in_stall),
        .i_adv        (adv),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    vbrf_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_item_valid   (item_valid),
        .i_item         (item),
        .o_adv          (adv),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_out    (o_pixel_out),
        .o_buffer_index (o_buffer_index),
        .o_was_veiled   (o_was_veiled),
        .o_last         (o_last)
    );

endmodule
